// ===== rtl/smpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpwm_pkg
// shared types and constants of the sorted multichannel pwm block
// ----------------------------------------------------------------------------
package smpwm_pkg;

  localparam int CHANNELS_DEFAULT = 4;
  localparam int PIN_W            = 3;
  localparam int DUTY_W           = 8;
  localparam int NUM_PINS         = 8;
  localparam int COUNT_OUT_W      = 3;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_STOP     = 2'd1,
    MODE_OVERFLOW = 2'd2,
    MODE_MATCH    = 2'd3
  } mode_t;

  // one table entry: pin and its turn-off count
  typedef struct packed {
    logic [PIN_W-1:0]  pin;
    logic [DUTY_W-1:0] duty;
  } entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              do_remove;
    logic              do_insert;
    logic              do_load;
    logic [PIN_W-1:0]  pin;
    logic [DUTY_W-1:0] duty;
  } cell_ctl_t;

endpackage

// ===== rtl/smpwm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpwm_cell
// one slot of the sorted duty list: pending entry, active entry, shift logic
// ----------------------------------------------------------------------------
module smpwm_cell (
  input  logic                clk,
  input  smpwm_pkg::cell_ctl_t ctl,
  input  logic                pend_valid,
  input  smpwm_pkg::entry_t   from_left,
  input  smpwm_pkg::entry_t   from_right,
  input  logic                seen_in,
  input  logic                ins_in,
  output logic                seen_out,
  output logic                ins_out,
  output smpwm_pkg::entry_t   pend,
  output smpwm_pkg::entry_t   act
);
  import smpwm_pkg::*;

  logic   moved;
  logic   hit;
  logic   ins_here;
  entry_t new_entry;

  always_comb begin
    hit       = pend_valid && (pend.pin == ctl.pin);
    seen_out  = seen_in | hit;
    // slot sits behind the removed pin: equal duties here go after the new one
    ins_here  = !pend_valid || (pend.duty > ctl.duty) ||
                ((pend.duty == ctl.duty) && moved);
    ins_out   = ins_in | ins_here;
    new_entry = '{pin: ctl.pin, duty: ctl.duty};
  end

  always_ff @(posedge clk) begin
    if (ctl.do_remove) begin
      moved <= seen_out;
      if (seen_out) begin
        pend <= from_right;
      end
    end else if (ctl.do_insert) begin
      if (ins_in) begin
        pend <= from_left;
      end else if (ins_here) begin
        pend <= new_entry;
      end
    end
    if (ctl.do_load) begin
      act <= pend;
    end
  end

endmodule

// ===== rtl/sorted_multichannel_pwm_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_multichannel_pwm_top
// double-buffered multichannel pwm with a sorted compare list
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; busy then stays high
// until the result has been shown. Every item gives exactly one result, held on
// accepted, pin_levels, compare_value and channel_count for the single cycle in
// which done is high; the receiver cannot stall, so it must sample that cycle.
// Timing is set by the sequencer that walks the row of list cells: a stop, or
// a start refused on a full list, goes from S_REMOVE to S_DONE; a start goes
// through S_REMOVE and S_INSERT, an overflow through S_LOAD and S_RISE, and a
// compare match through S_MATCH and S_ADVANCE (a match with an empty active
// list skips S_ADVANCE). busy drops when done does, so a new item can be taken
// at the end of the cycle after done.
// Pending list entries shift one slot per command through neighbor links;
// the active list is copied from it at a period overflow if a reload is armed.
// ----------------------------------------------------------------------------
module sorted_multichannel_pwm_top #(
  parameter int CHANNELS = smpwm_pkg::CHANNELS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            mode,
  input  logic [smpwm_pkg::PIN_W-1:0]           pin,
  input  logic [smpwm_pkg::DUTY_W-1:0]          duty,
  output logic                                  done,
  output logic                                  accepted,
  output logic [smpwm_pkg::NUM_PINS-1:0]        pin_levels,
  output logic [smpwm_pkg::DUTY_W-1:0]          compare_value,
  output logic [smpwm_pkg::COUNT_OUT_W-1:0]     channel_count
);
  import smpwm_pkg::*;

  localparam int CW = $clog2(CHANNELS + 1);
  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_REMOVE  = 8'b0000_0010,
    S_INSERT  = 8'b0000_0100,
    S_LOAD    = 8'b0000_1000,
    S_RISE    = 8'b0001_0000,
    S_MATCH   = 8'b0010_0000,
    S_ADVANCE = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t               state;
  mode_t                op_mode;
  logic [PIN_W-1:0]     op_pin;
  logic [DUTY_W-1:0]    op_duty;
  logic [CW-1:0]        pend_count;
  logic [CW-1:0]        act_count;
  logic                 reload_armed;
  logic [IW-1:0]        next_index;
  logic [NUM_PINS-1:0]  levels;
  logic [DUTY_W-1:0]    compare_reg;
  logic                 accepted_reg;

  // cell chain wiring
  cell_ctl_t            ctl;
  entry_t               pend_ent [CHANNELS];
  entry_t               act_ent  [CHANNELS];
  entry_t               left_ent [CHANNELS];
  entry_t               right_ent[CHANNELS];
  logic [CHANNELS-1:0]  pend_valid;
  logic [CHANNELS-1:0]  act_valid;
  logic [CHANNELS:0]    seen;
  logic [CHANNELS:0]    ins;

  logic                 found;
  logic                 full;
  logic [DUTY_W-1:0]    cur_duty;
  logic [NUM_PINS-1:0]  rise_mask;
  logic [NUM_PINS-1:0]  clr_mask;
  logic                 gt_found;
  logic [IW-1:0]        gt_index;
  logic                 match_live;

  assign seen[0] = 1'b0;
  assign ins[0]  = 1'b0;

  // sequencer broadcast to the row
  always_comb begin
    ctl.do_remove = (state == S_REMOVE);
    ctl.do_insert = (state == S_INSERT);
    ctl.do_load   = (state == S_LOAD) && reload_armed;
    ctl.pin       = op_pin;
    ctl.duty      = op_duty;
  end

  // the row of list cells, each linked to its neighbors
  for (genvar j = 0; j < CHANNELS; j++) begin : g_cell
    assign pend_valid[j] = (pend_count > CW'(j));
    assign act_valid[j]  = (act_count > CW'(j));

    if (j == 0) begin : g_first
      assign left_ent[j] = '0;
    end else begin : g_mid_l
      assign left_ent[j] = pend_ent[j-1];
    end

    if (j == CHANNELS - 1) begin : g_last
      assign right_ent[j] = '0;
    end else begin : g_mid_r
      assign right_ent[j] = pend_ent[j+1];
    end

    smpwm_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pend_valid (pend_valid[j]),
      .from_left  (left_ent[j]),
      .from_right (right_ent[j]),
      .seen_in    (seen[j]),
      .ins_in     (ins[j]),
      .seen_out   (seen[j+1]),
      .ins_out    (ins[j+1]),
      .pend       (pend_ent[j]),
      .act        (act_ent[j])
    );
  end

  assign found      = seen[CHANNELS];
  assign full       = (pend_count == CW'(CHANNELS));
  assign cur_duty   = act_ent[next_index].duty;
  assign match_live = (act_count != '0) && (CW'(next_index) < act_count);

  // pin masks of the active list and the current duty group, and the next larger group
  always_comb begin
    rise_mask = '0;
    clr_mask  = '0;
    gt_found  = 1'b0;
    gt_index  = '0;
    for (int j = CHANNELS - 1; j >= 0; j--) begin
      if (act_valid[j]) begin
        rise_mask = rise_mask | (NUM_PINS'(1) << act_ent[j].pin);
        if (act_ent[j].duty == cur_duty) begin
          clr_mask = clr_mask | (NUM_PINS'(1) << act_ent[j].pin);
        end
        if (act_ent[j].duty > cur_duty) begin
          gt_found = 1'b1;
          gt_index = IW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend_count   <= '0;
      act_count    <= '0;
      reload_armed <= 1'b0;
      next_index   <= '0;
      levels       <= '0;
      compare_reg  <= '0;
      accepted_reg <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_mode      <= mode_t'(mode);
            op_pin       <= pin;
            op_duty      <= duty;
            accepted_reg <= 1'b1;
            unique case (mode_t'(mode))
              MODE_START,
              MODE_STOP:     state <= S_REMOVE;
              MODE_OVERFLOW: state <= S_LOAD;
              MODE_MATCH:    state <= S_MATCH;
            endcase
          end
        end
        // cells drop the matching pin and close the gap
        S_REMOVE: begin
          if (found) begin
            pend_count <= pend_count - CW'(1);
          end
          if (op_mode == MODE_STOP) begin
            accepted_reg <= found;
            if (found) begin
              levels       <= levels & ~(NUM_PINS'(1) << op_pin);
              reload_armed <= 1'b1;
            end
            state <= S_DONE;
          end else if (!found && full) begin
            accepted_reg <= 1'b0;
            state        <= S_DONE;
          end else begin
            state <= S_INSERT;
          end
        end
        // cells open a slot at the sorted position
        S_INSERT: begin
          pend_count   <= pend_count + CW'(1);
          reload_armed <= 1'b1;
          state        <= S_DONE;
        end
        S_LOAD: begin
          if (reload_armed) begin
            act_count    <= pend_count;
            reload_armed <= 1'b0;
          end
          state <= S_RISE;
        end
        S_RISE: begin
          levels     <= levels | rise_mask;
          next_index <= '0;
          if (act_count != '0) begin
            compare_reg <= act_ent[0].duty;
          end
          state <= S_DONE;
        end
        S_MATCH: begin
          if (match_live) begin
            levels <= levels & ~clr_mask;
            if (gt_found) begin
              next_index <= gt_index;
            end
            state <= S_ADVANCE;
          end else begin
            state <= S_DONE;
          end
        end
        S_ADVANCE: begin
          compare_reg <= cur_duty;
          state       <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign accepted      = accepted_reg;
  assign pin_levels    = levels;
  assign compare_value = compare_reg;
  assign channel_count = COUNT_OUT_W'(pend_count);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= CW'(CHANNELS))
    else $error("pending count above list size");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but sequencer not started");

  a_load_disarms: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |=> !reload_armed)
    else $error("reload still armed after overflow");

  a_index_in_list: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && (act_count != '0)) |-> (CW'(next_index) < act_count))
    else $error("compare index beyond active list");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted multichannel pwm block
// ----------------------------------------------------------------------------
// A queue of commands and timer events is built at time zero. It starts with a
// short directed run through the corner cases, then adds random pwm periods:
// a few start and stop commands, one overflow, then some matches, with some
// noise mixed in. A clocked driver offers the items over start/busy with
// random gaps that change from phase to phase. At each accept it runs its own
// copy of the duty tables and logs the result it expects. A monitor checks
// every done strobe against the oldest logged result, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import smpwm_pkg::*;

  localparam int NCH        = CHANNELS_DEFAULT;
  localparam int ITEM_GOAL  = 1400;
  localparam int PHASE_LEN  = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE     = 20;

  typedef struct {
    mode_t             mode;
    logic [PIN_W-1:0]  pin;
    logic [DUTY_W-1:0] duty;
    bit                drain;    // hold off until every result is back
    int                gap_pct;  // chance of an idle cycle before this item
  } pwm_cmd_t;

  typedef struct {
    logic                   accepted;
    logic [NUM_PINS-1:0]    pin_levels;
    logic [DUTY_W-1:0]      compare_value;
    logic [COUNT_OUT_W-1:0] channel_count;
  } pwm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] mode = MODE_START;
  logic [PIN_W-1:0] pin = '0;
  logic [DUTY_W-1:0] duty = '0;
  logic busy, done, accepted;
  logic [NUM_PINS-1:0] pin_levels;
  logic [DUTY_W-1:0] compare_value;
  logic [COUNT_OUT_W-1:0] channel_count;

  pwm_cmd_t    command_q[$];
  pwm_result_t expected_outputs[$];
  int items_in = 0;
  int dones_seen = 0;
  int mismatches = 0;
  logic [DUTY_W-1:0] last_duty = '0;

  // shadow copy of the block state
  logic [DUTY_W-1:0] pend_duty[NCH];
  logic [PIN_W-1:0]  pend_pin[NCH];
  int                pend_cnt = 0;
  logic [DUTY_W-1:0] act_duty[NCH];
  logic [PIN_W-1:0]  act_pin[NCH];
  int                act_cnt = 0;
  bit                reload_armed = 1'b0;
  int                next_idx = 0;
  logic [NUM_PINS-1:0] levels = '0;
  logic [DUTY_W-1:0] cmp_reg = '0;

  sorted_multichannel_pwm_top #(.CHANNELS(NCH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .pin(pin), .duty(duty),
    .done(done), .accepted(accepted), .pin_levels(pin_levels),
    .compare_value(compare_value), .channel_count(channel_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one item to the shadow state and return what the block shows next
  function automatic pwm_result_t next_pwm_outputs(pwm_cmd_t c);
    pwm_result_t r;
    int i, j, k;
    bit hit, stop_walk;
    logic [DUTY_W-1:0] t_duty, cur;
    logic [PIN_W-1:0] t_pin;
    r.accepted = 1'b1;
    case (c.mode)
      MODE_START: begin
        hit = 1'b0;
        // update in place if the pin is already listed
        for (i = 0; i < pend_cnt; i++)
          if (!hit && pend_pin[i] == c.pin) begin
            pend_duty[i] = c.duty;
            hit = 1'b1;
          end
        // otherwise append when there is room
        if (!hit && pend_cnt < NCH) begin
          pend_duty[pend_cnt] = c.duty;
          pend_pin[pend_cnt] = c.pin;
          pend_cnt++;
          hit = 1'b1;
        end
        if (hit) begin
          // stable insertion sort by ascending duty
          for (i = 1; i < pend_cnt; i++) begin
            j = i;
            while (j > 0 && pend_duty[j-1] > pend_duty[j]) begin
              t_duty = pend_duty[j-1];
              pend_duty[j-1] = pend_duty[j];
              pend_duty[j] = t_duty;
              t_pin = pend_pin[j-1];
              pend_pin[j-1] = pend_pin[j];
              pend_pin[j] = t_pin;
              j--;
            end
          end
          reload_armed = 1'b1;
        end
        r.accepted = hit;
      end
      MODE_STOP: begin
        k = 0;
        while (k < pend_cnt && pend_pin[k] != c.pin) k++;
        if (k >= pend_cnt) begin
          r.accepted = 1'b0;
        end else begin
          for (; k + 1 < pend_cnt; k++) begin
            pend_duty[k] = pend_duty[k+1];
            pend_pin[k] = pend_pin[k+1];
          end
          pend_cnt--;
          levels[c.pin] = 1'b0;
          reload_armed = 1'b1;
        end
      end
      MODE_OVERFLOW: begin
        if (reload_armed) begin
          for (i = 0; i < pend_cnt; i++) begin
            act_duty[i] = pend_duty[i];
            act_pin[i] = pend_pin[i];
          end
          act_cnt = pend_cnt;
          reload_armed = 1'b0;
        end
        for (i = 0; i < act_cnt; i++) levels[act_pin[i]] = 1'b1;
        next_idx = 0;
        if (act_cnt > 0) cmp_reg = act_duty[0];
      end
      default: begin
        // compare match: drop the current duty group, move to the next one
        if (act_cnt != 0 && next_idx < act_cnt) begin
          cur = act_duty[next_idx];
          stop_walk = 1'b0;
          for (i = next_idx; i < act_cnt; i++)
            if (!stop_walk) begin
              if (act_duty[i] == cur) begin
                levels[act_pin[i]] = 1'b0;
              end else if (act_duty[i] > cur) begin
                next_idx = i;
                stop_walk = 1'b1;
              end
            end
          cmp_reg = act_duty[next_idx];
        end
      end
    endcase
    r.pin_levels = levels;
    r.compare_value = cmp_reg;
    r.channel_count = pend_cnt[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // gap chance follows the phase of the item's position in the run
  task automatic add_cmd(mode_t m, int p, int d, bit drain);
    pwm_cmd_t c;
    int phase;
    phase = (command_q.size() / PHASE_LEN) % 4;
    c.mode = m;
    c.pin = p[PIN_W-1:0];
    c.duty = d[DUTY_W-1:0];
    c.drain = drain;
    case (phase)
      1: c.gap_pct = 75;
      3: c.gap_pct = 20;
      default: c.gap_pct = 0;  // no gaps; the result side cannot stall anyway
    endcase
    command_q.push_back(c);
  endtask

  // duties lean toward the extremes and toward repeats, so groups form
  function automatic int pick_duty();
    int d;
    case ($urandom_range(5))
      0: d = 0;
      1: d = 255;
      2: d = last_duty;
      default: d = $urandom_range(255);
    endcase
    last_duty = d[DUTY_W-1:0];
    return d;
  endfunction

  // ---------------------------------------------------------------- stimulus
  initial begin
    int ncmd, nmatch, n;
    // directed corner cases
    add_cmd(MODE_MATCH, $urandom_range(7), $urandom_range(255), 1'b0);    // match, empty
    add_cmd(MODE_OVERFLOW, $urandom_range(7), $urandom_range(255), 1'b0); // no reload armed
    add_cmd(MODE_STOP, 7, 255, 1'b0);                                     // absent pin
    add_cmd(MODE_START, 0, 255, 1'b0);
    add_cmd(MODE_START, 7, 0, 1'b0);
    add_cmd(MODE_START, 3, 0, 1'b0);                                      // shared duty
    add_cmd(MODE_START, 5, 128, 1'b0);
    add_cmd(MODE_START, 6, 10, 1'b0);                                     // table full
    add_cmd(MODE_START, 5, 0, 1'b0);                                      // update when full
    add_cmd(MODE_START, 5, 200, 1'b0);                                    // update, re-sort
    add_cmd(MODE_OVERFLOW, $urandom_range(7), $urandom_range(255), 1'b1); // drain first
    for (n = 0; n < 4; n++)                                               // past last group
      add_cmd(MODE_MATCH, $urandom_range(7), $urandom_range(255), 1'b0);
    add_cmd(MODE_OVERFLOW, $urandom_range(7), $urandom_range(255), 1'b0); // keep active table
    add_cmd(MODE_STOP, 7, 0, 1'b0);                                       // active pin drops now
    add_cmd(MODE_MATCH, $urandom_range(7), $urandom_range(255), 1'b0);
    add_cmd(MODE_STOP, 7, 0, 1'b0);                                       // already gone
    add_cmd(MODE_STOP, 0, 0, 1'b0);
    add_cmd(MODE_STOP, 3, 0, 1'b0);
    add_cmd(MODE_STOP, 5, 0, 1'b0);                                       // table now empty
    add_cmd(MODE_OVERFLOW, $urandom_range(7), $urandom_range(255), 1'b0); // empty reload
    add_cmd(MODE_MATCH, $urandom_range(7), $urandom_range(255), 1'b0);

    // random pwm periods with some noise
    while (command_q.size() < ITEM_GOAL) begin
      if ($urandom_range(99) < 12) begin
        n = $urandom_range(3);
        add_cmd(mode_t'(n), $urandom_range(7), $urandom_range(255), 1'b0);
      end else begin
        ncmd = $urandom_range(3);
        for (n = 0; n < ncmd; n++)
          if ($urandom_range(2) == 0)
            add_cmd(MODE_STOP, $urandom_range(7), $urandom_range(255), 1'b0);
          else
            add_cmd(MODE_START, $urandom_range(7), pick_duty(), 1'b0);
        add_cmd(MODE_OVERFLOW, $urandom_range(7), $urandom_range(255),
                $urandom_range(9) == 0);
        nmatch = $urandom_range(5);
        for (n = 0; n < nmatch; n++)
          add_cmd(MODE_MATCH, $urandom_range(7), $urandom_range(255), 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for the queue to empty and every result to come back
    while (command_q.size() != 0 || items_in != dones_seen) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (expected_outputs.size() != 0)
        $display("%0d results never arrived", expected_outputs.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    pwm_cmd_t c;
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (done) dones_seen++;
      // item taken at this edge: run the shadow state and log the result
      if (start && !busy) begin
        c = command_q.pop_front();
        expected_outputs.push_back(next_pwm_outputs(c));
        items_in++;
      end
      if (!(start && busy)) begin
        go = command_q.size() != 0;
        if (go && command_q[0].drain && items_in != dones_seen) go = 1'b0;
        if (go && $urandom_range(99) < command_q[0].gap_pct) go = 1'b0;
        if (go) begin
          start <= 1'b1;
          mode <= command_q[0].mode;
          pin <= command_q[0].pin;
          duty <= command_q[0].duty;
        end else begin
          // idle: fields carry junk
          start <= 1'b0;
          mode <= 2'($urandom_range(3));
          pin <= PIN_W'($urandom_range(7));
          duty <= DUTY_W'($urandom_range(255));
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  // done is registered, so the mid-cycle value is the one taken at the edge
  always @(negedge clk) begin
    pwm_result_t e;
    if (!rst && done) begin
      if (expected_outputs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: acc %0b levels %02h cmp %0d cnt %0d",
                   accepted, pin_levels, compare_value, channel_count);
        mismatches++;
      end else begin
        e = expected_outputs.pop_front();
        if (accepted !== e.accepted || pin_levels !== e.pin_levels ||
            compare_value !== e.compare_value || channel_count !== e.channel_count) begin
          if (mismatches < 10)
            $display({"mismatch at %0t: exp acc %0b levels %02h cmp %0d cnt %0d,",
                      " got acc %0b levels %02h cmp %0d cnt %0d"},
                     $realtime, e.accepted, e.pin_levels, e.compare_value,
                     e.channel_count, accepted, pin_levels, compare_value,
                     channel_count);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    int quiet;
    if (rst || (start && !busy) || done) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
